// ===== sv/oswr_pkg.sv =====
// ----------------------------------------------------------------------------
// oswr_pkg
// Shared sizes, codes and cell control type for the ordered store.
// ----------------------------------------------------------------------------
package oswr_pkg;

  localparam int Depth = 16;
  localparam int OccW  = $clog2(Depth + 1);
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_REMOVE     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             cmp;
    logic             push_front;
    logic             push_back;
    logic             remove;
    logic [DataW-1:0] value;
  } cell_ctl_t;

endpackage

// ===== sv/oswr_cell.sv =====
// ----------------------------------------------------------------------------
// oswr_cell
// One position of the store: holds an entry, compares it, shifts it.
// ----------------------------------------------------------------------------
module oswr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  oswr_pkg::cell_ctl_t           ctl_i,
  input  logic                          valid_i,
  input  logic                          tail_i,
  input  logic [oswr_pkg::DataW-1:0]    left_i,
  input  logic [oswr_pkg::DataW-1:0]    right_i,
  input  logic                          hit_i,
  output logic [oswr_pkg::DataW-1:0]    data_o,
  output logic                          hit_o
);

  logic [oswr_pkg::DataW-1:0] data_q, data_d;
  logic                       match_q, match_d;

  // pass the "match seen at or before here" flag to the right neighbor
  assign hit_o  = hit_i | match_q;
  assign data_o = data_q;

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    if (ctl_i.cmp) begin
      match_d = valid_i && (data_q == ctl_i.value);
    end
    if (ctl_i.push_front) begin
      data_d = left_i;
    end else if (ctl_i.push_back && tail_i) begin
      data_d = ctl_i.value;
    end else if (ctl_i.remove && hit_o) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== sv/ordered_store_with_remove_by_value.sv =====
// ----------------------------------------------------------------------------
// ordered_store_with_remove_by_value
// Double-ended store of signed words with insert at either end and removal
// of the first entry equal to a given value.
// ----------------------------------------------------------------------------
// Timing: an accepted item passes the compare state (ST_MATCH), then the apply
// state (ST_APPLY); the done register then strobes its result.
// No new item is taken while busy, as the compare pass registers a match bit
// in every cell before the shift pass that applies the item.
// Reset: occupancy clears to zero; entries keep whatever they held.
// The receiver cannot stall: each result shows on done_o for one cycle only.
module ordered_store_with_remove_by_value (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  count_o,
  output logic        is_empty_o
);

  // Sequencer: take the item, compare in every cell, then apply.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                   func_q;
  logic [oswr_pkg::DataW-1:0]   value_q;
  logic [oswr_pkg::OccW-1:0]    occ_q, occ_d;

  logic                         done_q;
  logic [1:0]                   status_q;
  logic [4:0]                   count_q;
  logic                         empty_q;

  oswr_pkg::status_e            status_d;
  oswr_pkg::cell_ctl_t          ctl;

  logic [oswr_pkg::DataW-1:0]   cell_data [oswr_pkg::Depth];
  logic [oswr_pkg::Depth:0]     hit_chain;

  logic accept;
  logic is_full, is_empty, found;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign is_full  = (occ_q == oswr_pkg::OccW'(oswr_pkg::Depth));
  assign is_empty = (occ_q == '0);
  // the last cell's outgoing flag says some valid entry matched
  assign found    = hit_chain[oswr_pkg::Depth];
  assign hit_chain[0] = 1'b0;

  // Work out the outcome of the item during the apply cycle.
  always_comb begin
    status_d       = oswr_pkg::STATUS_OK;
    occ_d          = occ_q;
    ctl.cmp        = (state_q == ST_MATCH);
    ctl.push_front = 1'b0;
    ctl.push_back  = 1'b0;
    ctl.remove     = 1'b0;
    ctl.value      = value_q;
    if (state_q == ST_APPLY) begin
      case (func_q)
        oswr_pkg::FUNC_PUSH_FRONT: begin
          if (is_full) begin
            status_d = oswr_pkg::STATUS_FULL;
          end else begin
            ctl.push_front = 1'b1;
            occ_d          = occ_q + 1'b1;
          end
        end
        oswr_pkg::FUNC_PUSH_BACK: begin
          if (is_full) begin
            status_d = oswr_pkg::STATUS_FULL;
          end else begin
            ctl.push_back = 1'b1;
            occ_d         = occ_q + 1'b1;
          end
        end
        oswr_pkg::FUNC_REMOVE: begin
          if (is_empty) begin
            status_d = oswr_pkg::STATUS_EMPTY;
          end else if (!found) begin
            status_d = oswr_pkg::STATUS_NOT_FOUND;
          end else begin
            ctl.remove = 1'b1;
            occ_d      = occ_q - 1'b1;
          end
        end
        default: begin
          // unused code: leave the store alone, report ok
          status_d = oswr_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= (state_q == ST_APPLY);
    end
  end

  // Hold the item and the result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    if (state_q == ST_APPLY) begin
      status_q <= status_d;
      count_q  <= 5'(occ_d);
      empty_q  <= (occ_d == '0);
    end
  end

  // Row of cells: cell 0 takes the new value on a front insert, each cell
  // takes its left neighbor's entry; on removal each cell at or past the hit
  // takes its right neighbor's entry, closing the gap.
  for (genvar i = 0; i < oswr_pkg::Depth; i++) begin : g_cell
    logic [oswr_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_q;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == oswr_pkg::Depth - 1) begin : g_last
      assign right = value_q;
    end else begin : g_inner
      assign right = cell_data[i+1];
    end

    oswr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .valid_i (oswr_pkg::OccW'(i) < occ_q),
      .tail_i  (oswr_pkg::OccW'(i) == occ_q),
      .left_i  (left),
      .right_i (right),
      .hit_i   (hit_chain[i]),
      .data_o  (cell_data[i]),
      .hit_o   (hit_chain[i+1])
    );
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign count_o    = count_q;
  assign is_empty_o = empty_q;

endmodule
